// ===== sv/cmmd_pkg.sv =====
// Shared types and codes for the CPU memory map decoder.
// No dependencies; imported by cmmd_decode and cpu_memory_map_decoder.
`default_nettype none

package cmmd_pkg;

	// Bus access kinds
	localparam logic [1:0] OP_FETCH   = 2'd0;
	localparam logic [1:0] OP_OPERAND = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_WRITE   = 2'd3;

	// Routing targets
	localparam logic [2:0] TGT_RAM = 3'd0;
	localparam logic [2:0] TGT_ROM = 3'd1;
	localparam logic [2:0] TGT_REG = 3'd2;
	localparam logic [2:0] TGT_PFD = 3'd3;
	localparam logic [2:0] TGT_PFC = 3'd4;
	localparam logic [2:0] TGT_IGN = 3'd5;

	// Pages and offsets of the upper map
	localparam logic [7:0] PAGE_FC     = 8'hFC;
	localparam logic [7:0] PAGE_FD     = 8'hFD;
	localparam logic [7:0] PAGE_ROM    = 8'hFE;
	localparam logic [7:0] PAGE_TOP    = 8'hFF;
	localparam logic [7:0] OFF_RAM     = 8'hF8;
	localparam logic [7:0] OFF_MAPREG  = 8'hF9;
	localparam logic [7:0] OFF_VECTORS = 8'hFA;

	localparam logic [16:0] SEQ_NONE = 17'h1FFFF;
	localparam logic [2:0]  COST_SLOW = 3'd5;
	localparam logic [2:0]  COST_FAST = 3'd4;
	localparam logic [3:0]  REG_READ_HIGH = 4'hF;

	// Map-control bit positions
	localparam int MAP_SEQ_OFF = 4;
	localparam int MAP_VEC_OFF = 3;
	localparam int MAP_KER_OFF = 2;
	localparam int MAP_FD_OFF  = 1;
	localparam int MAP_FC_OFF  = 0;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] access_address;
		logic [7:0]  write_data;
	} access_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [15:0] memory_address;
		logic        write_enable;
		logic [7:0]  register_read_data;
		logic [2:0]  cycle_cost;
		logic        fetch_fault;
	} result_t;

	// State update produced by one decoded access
	typedef struct packed {
		logic        seq_load;
		logic [16:0] seq_next;
		logic        map_load;
		logic [4:0]  map_next;
	} state_upd_t;

endpackage

`default_nettype wire

// ===== sv/cmmd_decode.sv =====
// Combinational decode of one bus access against the current map state.
// Depends on cmmd_pkg.
`default_nettype none

module cmmd_decode (
	input  var cmmd_pkg::access_t    acc,
	input  wire [4:0]                mapping_bits,
	input  wire [16:0]               next_seq_addr,
	output cmmd_pkg::result_t        res,
	output cmmd_pkg::state_upd_t     upd
);
	import cmmd_pkg::*;

	logic [7:0] page;
	logic [7:0] off;
	logic       wr;
	logic       fetch;
	logic       periph;
	logic       ram_here;

	assign page  = acc.access_address[15:8];
	assign off   = acc.access_address[7:0];
	assign wr    = (acc.opcode == OP_WRITE);
	assign fetch = (acc.opcode == OP_FETCH) || (acc.opcode == OP_OPERAND);
	assign periph = (page == PAGE_FD && !mapping_bits[MAP_FD_OFF]) ||
		(page == PAGE_FC && !mapping_bits[MAP_FC_OFF]);

	// RAM shows through the top page where the overlay is switched off
	always_comb begin
		priority if (off >= OFF_VECTORS) begin
			ram_here = mapping_bits[MAP_VEC_OFF];
		end else if (off < OFF_RAM) begin
			ram_here = mapping_bits[MAP_KER_OFF];
		end else begin
			ram_here = (off == OFF_RAM);
		end
	end

	// Routing
	always_comb begin
		res = '0;
		res.target = TGT_RAM;
		res.memory_address = acc.access_address;
		priority if (periph) begin
			res.target = (page == PAGE_FD) ? TGT_PFD : TGT_PFC;
			res.fetch_fault = fetch;
			res.write_enable = wr;
		end else if (page == PAGE_ROM && !mapping_bits[MAP_KER_OFF]) begin
			if (wr) begin
				res.target = TGT_IGN;
				res.memory_address = '0;
			end else begin
				res.target = TGT_ROM;
				res.memory_address = {7'd0, acc.access_address[8:0]};
			end
		end else if (page == PAGE_TOP) begin
			priority if (off == OFF_MAPREG) begin
				res.target = TGT_REG;
				res.memory_address = '0;
				res.write_enable = wr;
				if (!wr) begin
					res.register_read_data = {REG_READ_HIGH, mapping_bits[3:0]};
				end
			end else if (ram_here) begin
				res.write_enable = wr;
			end else if (wr) begin
				res.target = TGT_IGN;
				res.memory_address = '0;
			end else begin
				res.target = TGT_ROM;
				res.memory_address = {8'd1, off};
			end
		end else begin
			res.write_enable = wr;
		end

		// Cost only on memory pages; peripherals time themselves
		if (!periph) begin
			if ({1'b0, acc.access_address} == next_seq_addr) begin
				res.cycle_cost = mapping_bits[MAP_SEQ_OFF] ? COST_SLOW : COST_FAST;
			end else begin
				res.cycle_cost = COST_SLOW;
			end
		end
	end

	// State update: sequential tracking and map register write
	always_comb begin
		upd.seq_load = !periph;
		upd.seq_next = wr ? SEQ_NONE : ({1'b0, acc.access_address} + 17'd1);
		upd.map_load = !periph && wr && (page == PAGE_TOP) && (off == OFF_MAPREG);
		upd.map_next = {acc.write_data[7], acc.write_data[3:0]};
	end

endmodule

`default_nettype wire

// ===== sv/cpu_memory_map_decoder.sv =====
// Top level of the CPU memory map decoder: stream ports, input and result registers.
// Depends on cmmd_pkg and cmmd_decode.
`default_nettype none

// Decodes one CPU bus access per beat into a target (RAM, ROM, map register,
// peripheral page FD or FC, or ignored), a memory address, a write enable, the
// map-register readback, the bus cycle cost and a fetch fault flag. The block
// takes one beat per clock unless the result side stalls; the beat is captured
// in an input register, decoded against the map-control bits and the tracked
// next sequential address, and the result lands in an output register. The
// state update happens as a beat leaves the input register, so the next beat
// already sees it. Back-pressure on the result side stalls both stages.
module cpu_memory_map_decoder (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [15:0] access_address, [23:16] write_data
	input  wire  [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  wire         m_tready,
	// [15:0] memory_address, [16] write_enable, [24:17] register_read_data,
	// [27:25] cycle_cost, [28] fetch_fault, [31:29] zero
	output logic [31:0] m_tdata,
	output logic [2:0]  m_tuser    // [2:0] target
);
	import cmmd_pkg::*;

	logic        valid_s1;
	access_t     acc_s1;
	logic        valid_s2;
	result_t     res_s2;
	logic [4:0]  mapping_q;
	logic [16:0] next_seq_q;
	logic        adv;
	result_t     res;
	state_upd_t  upd;

	// Stage 1 moves on when the result register is free or being drained
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	cmmd_decode u_decode (
		.acc           (acc_s1),
		.mapping_bits  (mapping_q),
		.next_seq_addr (next_seq_q),
		.res           (res),
		.upd           (upd)
	);

	// Control and map state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			mapping_q  <= '0;
			next_seq_q <= SEQ_NONE;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					if (upd.seq_load) begin
						next_seq_q <= upd.seq_next;
					end
					if (upd.map_load) begin
						mapping_q <= upd.map_next;
					end
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			acc_s1.opcode         <= s_tuser;
			acc_s1.access_address <= s_tdata[15:0];
			acc_s1.write_data     <= s_tdata[23:16];
		end
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.target;
	assign m_tdata  = {3'd0, res_s2.fetch_fault, res_s2.cycle_cost,
		res_s2.register_read_data, res_s2.write_enable, res_s2.memory_address};

endmodule

`default_nettype wire
